// ===== hdl/biq_pkg.sv =====
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types and constants for the direct-form-I biquad core: register
// indexes, sequencer step codes and the MAC control bundle.
// ----------------------------------------------------------------------------
package biq_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int STEP_W    = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd5;

	// MAC step codes, one product term each
	localparam logic [STEP_W-1:0] STEP_B0 = 3'd0;
	localparam logic [STEP_W-1:0] STEP_B1 = 3'd1;
	localparam logic [STEP_W-1:0] STEP_B2 = 3'd2;
	localparam logic [STEP_W-1:0] STEP_A1 = 3'd3;
	localparam logic [STEP_W-1:0] STEP_A2 = 3'd4;

	typedef struct packed {
		logic clear;
		logic vld;
		logic sub;
	} mac_ctl_t;

endpackage

// ===== hdl/biq_mac.sv =====
// ----------------------------------------------------------------------------
// biq_mac
// Shared multiply-accumulate unit: one registered signed product per cycle,
// added to or subtracted from the accumulator on the following cycle.
// ----------------------------------------------------------------------------
module biq_mac
	import biq_pkg::*;
#(
	parameter int COEF_BITS   = 18,
	parameter int SAMPLE_BITS = 16,
	parameter int ACC_W       = 36
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mac_ctl_t                      ctl,
	input  logic signed [COEF_BITS-1:0]   coef,
	input  logic signed [SAMPLE_BITS-1:0] data,
	output logic signed [ACC_W-1:0]       acc
);

	localparam int PROD_W = COEF_BITS + SAMPLE_BITS;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic                     sub_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;

	always_ff @(posedge clk) begin
		prod_s1 <= coef * data;
	end

	assign prod_ext = ACC_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			sub_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= ctl.vld;
			sub_s1 <= ctl.sub;
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (vld_s1) begin
				acc_q <= sub_s1 ? acc_q - prod_ext : acc_q + prod_ext;
			end
		end
	end

	assign acc = acc_q;

endmodule

// ===== hdl/biq_div.sv =====
// ----------------------------------------------------------------------------
// biq_div
// Serial restoring divider: one quotient bit per cycle on magnitudes, with
// the quotient sign kept apart (truncation toward zero).
// ----------------------------------------------------------------------------
module biq_div #(
	parameter int ACC_W     = 36,
	parameter int COEF_BITS = 18
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [ACC_W-1:0]     dividend,
	input  logic signed [COEF_BITS-1:0] divisor,
	output logic                        done,
	output logic [ACC_W-1:0]            quo_mag,
	output logic                        quo_neg
);

	localparam int CNT_W = $clog2(ACC_W + 1);

	logic [COEF_BITS-1:0] den_q;
	logic [COEF_BITS-1:0] rem_q;
	logic [ACC_W-1:0]     quo_q;
	logic                 neg_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [COEF_BITS:0]   rem_sh;
	logic [COEF_BITS+1:0] diff;

	assign rem_sh = {rem_q, quo_q[ACC_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ACC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[ACC_W-1] ^ divisor[COEF_BITS-1];
			quo_q <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
			den_q <= divisor[COEF_BITS-1] ? COEF_BITS'(-divisor) : COEF_BITS'(divisor);
			rem_q <= '0;
		end else if (busy_q) begin
			// keep the shifted remainder when the trial subtract goes negative
			rem_q <= diff[COEF_BITS+1] ? rem_sh[COEF_BITS-1:0] : diff[COEF_BITS-1:0];
			quo_q <= {quo_q[ACC_W-2:0], ~diff[COEF_BITS+1]};
		end
	end

	assign done    = done_q;
	assign quo_mag = quo_q;
	assign quo_neg = neg_q;

endmodule

// ===== hdl/iir_biquad_direct_form1_core.sv =====
// ----------------------------------------------------------------------------
// iir_biquad_direct_form1_core
// Fixed-point direct-form-I biquad: y = (b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2)
// divided by a0 (1.0 when a0 is zero), truncated and saturated.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/sample_in) takes one sample per beat.
//   Output channel (out_valid/out_ready/sample_out/saturated) returns one
//   filtered sample per input beat, in order.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the six
//   Q4.14 coefficients b0, b1, b2, a0, a1, a2 at indexes 0..5; other indexes
//   are dropped. cfg_ready is always high; write only while idle.
//   Each sample runs a sequence of steps: one MAC step per product term on a
//   single shared multiplier, a flush, a divider load, the serial division of
//   the (SAMPLE_BITS+COEF_FRAC_BITS+6)-bit dividend, the divider done flag and
//   the posting of the result. in_ready returns at the same clock edge that
//   posts the result, and is high only while the sequencer is idle, so a new
//   sample is not taken before the last one is through. A finished result
//   waits in the output register; the next sample is accepted meanwhile and
//   held at its final step until out_ready frees the register.
//   Reset clears coefficients and both histories to zero, so the output is
//   zero until coefficients are written.
// ----------------------------------------------------------------------------
module iir_biquad_direct_form1_core
	import biq_pkg::*;
#(
	parameter int FILTER_ORDER   = 2,
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [SAMPLE_BITS-1:0]      sample_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [SAMPLE_BITS-1:0]      sample_out,
	output logic                               saturated,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [CFG_IDX_W-1:0]               cfg_index,
	input  logic signed [COEF_FRAC_BITS+3:0]   cfg_data
);

	localparam int COEF_BITS = COEF_FRAC_BITS + 4;
	localparam int ACC_W     = COEF_BITS + SAMPLE_BITS + 2;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MAC    = 3'd1;
	localparam logic [2:0] ST_FLUSH  = 3'd2;
	localparam logic [2:0] ST_DSTART = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;

	localparam logic [STEP_W-1:0] STEP_LAST = (FILTER_ORDER >= 2) ? STEP_A2 : STEP_A1;

	localparam logic signed [COEF_BITS-1:0]   ONE      = COEF_BITS'(1 << COEF_FRAC_BITS);
	localparam logic [ACC_W-1:0]              MAG_POS  = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic [ACC_W-1:0]              MAG_NEG  = ACC_W'(1 << (SAMPLE_BITS - 1));
	localparam logic signed [SAMPLE_BITS-1:0] SMAX     = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMIN     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic [2:0]                    state_q;
	logic [STEP_W-1:0]             step_q;
	logic signed [COEF_BITS-1:0]   b0_q, b1_q, b2_q, a0_q, a1_q, a2_q;
	logic signed [SAMPLE_BITS-1:0] x_q, x1_q, x2_q, y1_q, y2_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          sat_q;

	mac_ctl_t                      mac_ctl;
	logic signed [COEF_BITS-1:0]   mac_coef;
	logic signed [SAMPLE_BITS-1:0] mac_data;
	logic                          mac_sub;
	logic signed [ACC_W-1:0]       acc;
	logic signed [COEF_BITS-1:0]   divisor;
	logic                          div_done;
	logic [ACC_W-1:0]              quo_mag;
	logic                          quo_neg;
	logic                          in_fire;
	logic                          fin_fire;
	logic                          sat_now;
	logic signed [SAMPLE_BITS-1:0] y_now;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign fin_fire  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;

	// operand select for the current product term
	always_comb begin
		unique case (step_q)
			STEP_B0: begin
				mac_coef = b0_q;
				mac_data = x_q;
				mac_sub  = 1'b0;
			end
			STEP_B1: begin
				mac_coef = b1_q;
				mac_data = x1_q;
				mac_sub  = 1'b0;
			end
			STEP_B2: begin
				mac_coef = b2_q;
				mac_data = x2_q;
				mac_sub  = 1'b0;
			end
			STEP_A1: begin
				mac_coef = a1_q;
				mac_data = y1_q;
				mac_sub  = 1'b1;
			end
			STEP_A2: begin
				mac_coef = a2_q;
				mac_data = y2_q;
				mac_sub  = 1'b1;
			end
			default: begin
				mac_coef = '0;
				mac_data = '0;
				mac_sub  = 1'b0;
			end
		endcase
	end

	assign mac_ctl.clear = in_fire;
	assign mac_ctl.vld   = (state_q == ST_MAC);
	assign mac_ctl.sub   = mac_sub;

	biq_mac #(
		.COEF_BITS   (COEF_BITS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.ACC_W       (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (mac_coef),
		.data   (mac_data),
		.acc    (acc)
	);

	assign divisor = (a0_q == '0) ? ONE : a0_q;

	biq_div #(
		.ACC_W     (ACC_W),
		.COEF_BITS (COEF_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DSTART),
		.dividend (acc),
		.divisor  (divisor),
		.done     (div_done),
		.quo_mag  (quo_mag),
		.quo_neg  (quo_neg)
	);

	// saturate on the magnitude, then restore the sign in sample width
	assign sat_now = quo_neg ? (quo_mag > MAG_NEG) : (quo_mag > MAG_POS);
	always_comb begin
		if (sat_now) begin
			y_now = quo_neg ? SMIN : SMAX;
		end else if (quo_neg) begin
			y_now = -quo_mag[SAMPLE_BITS-1:0];
		end else begin
			y_now = quo_mag[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= '0;
			b1_q <= '0;
			b2_q <= '0;
			a0_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_B0:  b0_q <= cfg_data;
				REG_B1:  b1_q <= cfg_data;
				REG_B2:  b2_q <= cfg_data;
				REG_A0:  a0_q <= cfg_data;
				REG_A1:  a1_q <= cfg_data;
				REG_A2:  a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_B0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_MAC;
						step_q  <= STEP_B0;
					end
				end
				ST_MAC: begin
					if (step_q == STEP_LAST) begin
						state_q <= ST_FLUSH;
					end else if (FILTER_ORDER < 2 && step_q == STEP_B1) begin
						step_q <= STEP_A1;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_FLUSH:  state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= sample_in;
		end
	end

	// advance both histories when the result is posted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (fin_fire) begin
			x1_q <= x_q;
			x2_q <= x1_q;
			y1_q <= y_now;
			y2_q <= y1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			sample_q <= y_now;
			sat_q    <= sat_now;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;
	assign saturated  = sat_q;

	a_post_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("output beat posted outside the finish step");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && sat_q) |-> (sample_q == SMAX || sample_q == SMIN))
		else $error("saturated beat carries a value inside the range");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide step");

	a_hist_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fin_fire |=> ($stable(y1_q) && $stable(x1_q)))
		else $error("history moved without a posted result");

endmodule

// ===== verif/tb_iir_biquad_direct_form1_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iir_biquad_direct_form1_core
// Self-checking bench for the fixed-point direct-form-I biquad. Coefficients
// are loaded between bursts of samples. Each accepted sample runs through a
// local copy of the filter, and each output beat is compared with the oldest
// filtered value still pending. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_iir_biquad_direct_form1_core;
	import biq_pkg::*;

	localparam int FILTER_ORDER   = 2;
	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_FRAC_BITS = 14;
	localparam int COEF_BITS      = COEF_FRAC_BITS + 4;
	localparam int HOLD_CYCLES    = 400;
	localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

	localparam logic signed [COEF_BITS-1:0] ONE_Q14  = 18'sd16384;
	localparam logic signed [COEF_BITS-1:0] COEF_MAX = 18'sd131071;
	localparam logic signed [COEF_BITS-1:0] COEF_MIN = -18'sd131072;
	// indexes past the last register; the block drops these writes
	localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_7 = 3'd7;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] y;
		logic                          clipped;
	} filt_out_t;

	typedef struct {
		logic [CFG_IDX_W-1:0]          idx;
		logic signed [COEF_BITS-1:0]   val;
	} coef_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SAMPLE_BITS-1:0] sample_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic signed [COEF_BITS-1:0] cfg_data = '0;

	// filter copy: coefficients and histories
	logic signed [COEF_BITS-1:0] c_b0 = '0, c_b1 = '0, c_b2 = '0;
	logic signed [COEF_BITS-1:0] c_a0 = '0, c_a1 = '0, c_a2 = '0;
	logic signed [SAMPLE_BITS-1:0] x_d1 = '0, x_d2 = '0, y_d1 = '0, y_d2 = '0;

	logic signed [SAMPLE_BITS-1:0] samples_to_send[$];
	coef_write_t coef_writes[$];
	filt_out_t filtered_pending[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int mismatches = 0;

	iir_biquad_direct_form1_core #(
		.FILTER_ORDER   (FILTER_ORDER),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.saturated  (saturated),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic filt_out_t filter_step(logic signed [SAMPLE_BITS-1:0] x);
		longint acc, dvs, q;
		filt_out_t r;
		acc = longint'(c_b0) * x + longint'(c_b1) * x_d1 - longint'(c_a1) * y_d1;
		if (FILTER_ORDER >= 2)
			acc = acc + longint'(c_b2) * x_d2 - longint'(c_a2) * y_d2;
		dvs = (c_a0 != 0) ? longint'(c_a0) : (longint'(1) <<< COEF_FRAC_BITS);
		q = acc / dvs;
		r.clipped = 1'b0;
		if (q > SAMPLE_MAX) begin
			q = SAMPLE_MAX;
			r.clipped = 1'b1;
		end else if (q < SAMPLE_MIN) begin
			q = SAMPLE_MIN;
			r.clipped = 1'b1;
		end
		r.y = q[SAMPLE_BITS-1:0];
		x_d2 = x_d1;
		x_d1 = x;
		y_d2 = y_d1;
		y_d1 = r.y;
		return r;
	endfunction

	function automatic logic signed [COEF_BITS-1:0] coef_between(int lo, int hi);
		return COEF_BITS'(lo + int'($urandom_range(hi - lo)));
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(9))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2, 3:    return SAMPLE_BITS'(int'($urandom_range(511)) - 256);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(4))
			0:       return 0;
			1:       return 10;
			2:       return 30;
			3:       return 60;
			default: return 85;
		endcase
	endfunction

	// driver: coefficient writes and sample beats, predicting on each accepted sample
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			sample_in <= '0;
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_B0:  c_b0 = cfg_data;
					REG_B1:  c_b1 = cfg_data;
					REG_B2:  c_b2 = cfg_data;
					REG_A0:  c_a0 = cfg_data;
					REG_A1:  c_a1 = cfg_data;
					REG_A2:  c_a2 = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				filtered_pending.push_back(filter_step(sample_in));

			if (cfg_valid && !cfg_ready) begin
				// hold
			end else if (coef_writes.size() != 0) begin
				coef_write_t w;
				w = coef_writes.pop_front();
				cfg_valid <= 1'b1;
				cfg_index <= w.idx;
				cfg_data  <= w.val;
			end else begin
				cfg_valid <= 1'b0;
			end

			if (in_valid && !in_ready) begin
				// hold
			end else if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
				send_gap = $urandom_range(13);
				in_valid <= 1'b0;
			end else if (samples_to_send.size() != 0) begin
				in_valid  <= 1'b1;
				sample_in <= samples_to_send.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check output beats and drive backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (filtered_pending.size() == 0) begin
					$error("sample_out: no output pending, got %0d", sample_out);
					mismatches++;
				end else begin
					filt_out_t exp_out;
					exp_out = filtered_pending.pop_front();
					if (sample_out !== exp_out.y) begin
						$error("sample_out: expected %0d, got %0d", exp_out.y, sample_out);
						mismatches++;
					end
					if (saturated !== exp_out.clipped) begin
						$error("saturated: expected %0b, got %0b", exp_out.clipped, saturated);
						mismatches++;
					end
				end
			end

			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
				recv_gap = $urandom_range(13);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic push_coef_write(logic [CFG_IDX_W-1:0] idx, logic signed [COEF_BITS-1:0] val);
		coef_write_t w;
		w.idx = idx;
		w.val = val;
		coef_writes.push_back(w);
	endtask

	task automatic load_coefs(logic signed [COEF_BITS-1:0] b0, logic signed [COEF_BITS-1:0] b1,
			logic signed [COEF_BITS-1:0] b2, logic signed [COEF_BITS-1:0] a0,
			logic signed [COEF_BITS-1:0] a1, logic signed [COEF_BITS-1:0] a2);
		@(negedge clk);
		push_coef_write(REG_B0, b0);
		push_coef_write(REG_B1, b1);
		push_coef_write(REG_B2, b2);
		push_coef_write(REG_A0, a0);
		push_coef_write(REG_A1, a1);
		push_coef_write(REG_A2, a2);
		if ($urandom_range(2) == 0)
			push_coef_write($urandom_range(1) ? IDX_UNUSED_6 : IDX_UNUSED_7, COEF_BITS'($urandom));
		while (coef_writes.size() != 0 || cfg_valid)
			@(negedge clk);
	endtask

	task automatic wait_all_out();
		while (samples_to_send.size() != 0 || in_valid || filtered_pending.size() != 0)
			@(negedge clk);
	endtask

	task automatic queue_samples(int n);
		@(negedge clk);
		repeat (n) samples_to_send.push_back(rand_sample());
	endtask

	task automatic random_setting(int kind);
		int p2;
		logic signed [COEF_BITS-1:0] a0;
		case (kind)
			0: begin
				// stable response: pole pair inside the unit circle
				p2 = int'($urandom_range(28000)) - 14000;
				a0 = $urandom_range(1) ? ONE_Q14 : '0;
				load_coefs(coef_between(-6000, 6000), coef_between(-6000, 6000),
					coef_between(-6000, 6000), a0,
					coef_between(-(16384 + p2) + 256, 16384 + p2 - 256), COEF_BITS'(p2));
			end
			1: begin
				load_coefs(COEF_BITS'($urandom), COEF_BITS'($urandom), COEF_BITS'($urandom),
					COEF_BITS'($urandom), COEF_BITS'($urandom), COEF_BITS'($urandom));
			end
			default: begin
				// small or negative divisor
				case ($urandom_range(2))
					0:       a0 = coef_between(1, 64);
					1:       a0 = coef_between(-64, -1);
					default: a0 = -ONE_Q14;
				endcase
				load_coefs(coef_between(-40000, 40000), coef_between(-40000, 40000),
					coef_between(-40000, 40000), a0,
					coef_between(-2000, 2000), coef_between(-2000, 2000));
			end
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// coefficients still at reset: output stays zero
		@(negedge clk);
		samples_to_send.push_back(16'sh7FFF);
		samples_to_send.push_back(16'sh8000);
		samples_to_send.push_back(16'sd1);
		wait_all_out();

		// gain near 8 with a0 zero: clips high and low; stray indexes dropped
		load_coefs(COEF_MAX, COEF_MIN, ONE_Q14, '0, '0, '0);
		push_coef_write(IDX_UNUSED_6, 18'sh1FFFF);
		push_coef_write(IDX_UNUSED_7, 18'sh2AAAA);
		while (coef_writes.size() != 0 || cfg_valid)
			@(negedge clk);
		samples_to_send.push_back(16'sh7FFF);
		samples_to_send.push_back(16'sh8000);
		samples_to_send.push_back(16'sh7FFF);
		samples_to_send.push_back(-16'sd1);
		samples_to_send.push_back(16'sd0);
		wait_all_out();

		// divisor of minus one: negating the most negative sample clips
		load_coefs(18'sd1, '0, '0, -18'sd1, '0, '0);
		samples_to_send.push_back(16'sd5);
		samples_to_send.push_back(16'sh8000);
		samples_to_send.push_back(-16'sd3);
		wait_all_out();

		// every coefficient at an extreme, feedback included
		load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN);
		samples_to_send.push_back(16'sh7FFF);
		samples_to_send.push_back(16'sh8000);
		samples_to_send.push_back(16'sd12345);
		samples_to_send.push_back(16'sh8000);
		samples_to_send.push_back(16'sh7FFF);
		wait_all_out();

		// ordinary lowpass, step then negative step
		load_coefs(18'sd4096, 18'sd8192, 18'sd4096, ONE_Q14, -18'sd20000, 18'sd8000);
		samples_to_send.push_back(16'sh7FFF);
		samples_to_send.push_back(16'sh7FFF);
		samples_to_send.push_back(16'sh7FFF);
		samples_to_send.push_back(16'sh8000);
		samples_to_send.push_back(16'sh8000);
		wait_all_out();

		for (int ph = 0; ph < 9; ph++) begin
			random_setting(ph % 3);
			@(negedge clk);
			send_idle_pct = (ph == 2 || ph == 4) ? 0 : pick_idle_pct();
			recv_idle_pct = (ph == 2) ? 0 : pick_idle_pct();
			queue_samples(95);
			// long receiver hold-off while samples keep coming
			if (ph == 4)
				hold_req++;
			// pause input until every output is back
			if (ph == 5)
				wait_all_out();
			queue_samples(95);
			wait_all_out();
		end

		// no idling in the closing stretch
		random_setting(0);
		@(negedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_samples(100);
		wait_all_out();

		repeat (60) @(posedge clk);
		if (mismatches == 0 && filtered_pending.size() == 0) begin
			$display("[iir_biquad_direct_form1_core] OK");
		end else begin
			$display("[iir_biquad_direct_form1_core] ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[iir_biquad_direct_form1_core] ERROR");
		$finish;
	end

endmodule
